// ----- hw/rtl/cpi_pkg.sv -----
`default_nettype none
package cpi_pkg;

    // Table geometry.
    localparam int ROWS    = 16;
    localparam int COLUMNS = 8;

    localparam int IDX_MAX = (ROWS > COLUMNS) ? ROWS : COLUMNS;
    localparam int IDX_W   = $clog2(IDX_MAX);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PA_W    = $clog2(ROWS * COLUMNS);

    // Field widths.
    localparam int X_W       = 7;
    localparam int PWR_W     = 16;
    localparam int WL_W      = 11;
    localparam int FRAC_W    = 8;
    localparam int OUT_W     = PWR_W + FRAC_W;
    localparam int PROD_W    = PWR_W + X_W;
    localparam int NUM_W     = PROD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int ADDR_W    = 3;

    // Request modes.
    localparam logic [1:0] MODE_LOAD_BP  = 2'd0;
    localparam logic [1:0] MODE_LOAD_PWR = 2'd1;
    localparam logic [1:0] MODE_LOAD_WL  = 2'd2;
    localparam logic [1:0] MODE_CONVERT  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NO_WL = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_COL_SCAN,
        OP_ROW_INIT,
        OP_ROW_SCAN,
        OP_FETCH_LO,
        OP_LOAD_Y0,
        OP_LOAD_Y1,
        OP_PREP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RESULT,
        OP_BASE,
        OP_ERR_WL,
        OP_ERR_X,
        OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_COL_MORE,
        C_NO_COLUMN,
        C_ROW_MORE,
        C_OUT_RANGE,
        C_ZERO_DX,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_COL_SCAN = 4'd1,
        ST_ROW_INIT = 4'd2,
        ST_ROW_SCAN = 4'd3,
        ST_RANGE    = 4'd4,
        ST_Y0       = 4'd5,
        ST_Y1       = 4'd6,
        ST_PREP     = 4'd7,
        ST_DIV_INIT = 4'd8,
        ST_DIV      = 4'd9,
        ST_RESULT   = 4'd10,
        ST_NO_WL    = 4'd12,
        ST_BASE     = 4'd13,
        ST_BAD_X    = 4'd14,
        ST_DONE     = 4'd15
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_start;
        logic col_more;
        logic no_column;
        logic row_more;
        logic out_range;
        logic zero_dx;
        logic div_more;
        logic out_busy;
    } flags_t;

    // The microprogram. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next step; the last step wraps to idle.
    function automatic ctrl_word_t microcode(input step_t s);
        ctrl_word_t w;
        case (s)
            ST_IDLE:     w = '{OP_IDLE,     C_NO_START,  ST_IDLE};
            ST_COL_SCAN: w = '{OP_COL_SCAN, C_COL_MORE,  ST_COL_SCAN};
            ST_ROW_INIT: w = '{OP_ROW_INIT, C_NO_COLUMN, ST_NO_WL};
            ST_ROW_SCAN: w = '{OP_ROW_SCAN, C_ROW_MORE,  ST_ROW_SCAN};
            ST_RANGE:    w = '{OP_FETCH_LO, C_OUT_RANGE, ST_BAD_X};
            ST_Y0:       w = '{OP_LOAD_Y0,  C_NEVER,     ST_IDLE};
            ST_Y1:       w = '{OP_LOAD_Y1,  C_NEVER,     ST_IDLE};
            ST_PREP:     w = '{OP_PREP,     C_ZERO_DX,   ST_BASE};
            ST_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,     ST_IDLE};
            ST_DIV:      w = '{OP_DIV_STEP, C_DIV_MORE,  ST_DIV};
            ST_RESULT:   w = '{OP_RESULT,   C_ALWAYS,    ST_DONE};
            ST_NO_WL:    w = '{OP_ERR_WL,   C_ALWAYS,    ST_DONE};
            ST_BASE:     w = '{OP_BASE,     C_ALWAYS,    ST_DONE};
            ST_BAD_X:    w = '{OP_ERR_X,    C_NEVER,     ST_IDLE};
            ST_DONE:     w = '{OP_DONE,     C_OUT_BUSY,  ST_DONE};
            default:     w = '{OP_IDLE,     C_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cpi_ram.sv -----
`default_nettype none
module cpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/cpi_seq.sv -----
`default_nettype none
module cpi_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  cpi_pkg::flags_t flags,
    output cpi_pkg::op_t    op,
    output cpi_pkg::step_t  step
);
    import cpi_pkg::*;

    step_t      pc_reg;
    step_t      pc_next;
    ctrl_word_t word;
    logic       take;

    assign word = microcode(pc_reg);

    always_comb
    begin
        case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_START:  take = flags.no_start;
            C_COL_MORE:  take = flags.col_more;
            C_NO_COLUMN: take = flags.no_column;
            C_ROW_MORE:  take = flags.row_more;
            C_OUT_RANGE: take = flags.out_range;
            C_ZERO_DX:   take = flags.zero_dx;
            C_DIV_MORE:  take = flags.div_more;
            C_OUT_BUSY:  take = flags.out_busy;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = step_t'(4'(pc_reg + 4'd1));
        end
    end

    always_comb
    begin
        op   = word.op;
        step = pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/cpi_dp.sv -----
`default_nettype none
module cpi_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  cpi_pkg::op_t    op,
    output cpi_pkg::flags_t flags,
    input  logic            item_accept,
    input  logic [1:0]      mode,
    input  logic [3:0]      row,
    input  logic [2:0]      column,
    input  logic [6:0]      intensity,
    input  logic [15:0]     table_value,
    input  logic            last_plane,
    input  logic [10:0]     selected_wavelength,
    input  logic [4:0]      rows_in_use,
    input  logic            result_stall,
    output logic            result_valid,
    output logic [23:0]     power,
    output logic [1:0]      status,
    output logic            last
);
    import cpi_pkg::*;

    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [IDX_W-1:0]     last_idx;
    logic [COL_W-1:0]     col_reg;
    logic                 col_found_reg;
    logic [ROW_W-1:0]     j_reg;
    logic                 brk_found_reg;
    logic [X_W-1:0]       x_reg;
    logic [X_W-1:0]       first_reg;
    logic [X_W-1:0]       last_bp_reg;
    logic [X_W-1:0]       prev_reg;
    logic [X_W-1:0]       a_reg;
    logic [X_W-1:0]       b_reg;
    logic [X_W-1:0]       dx_reg;
    logic                 lastp_reg;
    logic [PWR_W-1:0]     y0_reg;
    logic [PWR_W-1:0]     y1_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [X_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [OUT_W-1:0]     pwr_res_reg;
    logic [1:0]           st_res_reg;
    logic                 res_valid_reg;
    logic [OUT_W-1:0]     power_reg;
    logic [1:0]           status_reg;
    logic                 last_reg;

    logic                 bp_we;
    logic [ROW_W-1:0]     bp_waddr;
    logic [X_W-1:0]       bp_rdata;
    logic                 pw_we;
    logic [PA_W-1:0]      pw_waddr;
    logic [PA_W-1:0]      pw_raddr;
    logic [PA_W-1:0]      pw_addr_lo;
    logic [PA_W-1:0]      pw_addr_hi;
    logic [PWR_W-1:0]     pw_rdata;
    logic                 wl_we;
    logic [COL_W-1:0]     wl_waddr;
    logic [WL_W-1:0]      wl_rdata;

    logic [X_W:0]         rem_sh;
    logic                 q_bit;
    logic [X_W-1:0]       rem_new;
    logic [PWR_W-1:0]     dy;
    logic [OUT_W-1:0]     base;
    logic [OUT_W-1:0]     quot;
    logic                 done_load;

    // Table loads are taken only while the sequencer is idle.
    assign bp_we    = item_accept && (mode == MODE_LOAD_BP) && (32'(row) < ROWS);
    assign pw_we    = item_accept && (mode == MODE_LOAD_PWR) && (32'(row) < ROWS)
                      && (32'(column) < COLUMNS);
    assign wl_we    = item_accept && (mode == MODE_LOAD_WL) && (32'(column) < COLUMNS);
    assign bp_waddr = ROW_W'(row);
    assign wl_waddr = COL_W'(column);
    assign pw_waddr = PA_W'(PA_W'(row) * PA_W'(COLUMNS) + PA_W'(column));

    assign pw_addr_lo = PA_W'(PA_W'(j_reg) * PA_W'(COLUMNS) + PA_W'(col_reg));
    assign pw_addr_hi = PA_W'((PA_W'(j_reg) + PA_W'(1)) * PA_W'(COLUMNS) + PA_W'(col_reg));
    assign pw_raddr   = (op == OP_LOAD_Y0) ? pw_addr_hi : pw_addr_lo;

    cpi_ram #(.WIDTH(X_W), .DEPTH(ROWS)) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (intensity),
        .raddr (ROW_W'(idx_next)),
        .rdata (bp_rdata)
    );

    cpi_ram #(.WIDTH(PWR_W), .DEPTH(ROWS * COLUMNS)) u_pw_ram (
        .clk   (clk),
        .we    (pw_we),
        .waddr (pw_waddr),
        .wdata (table_value),
        .raddr (pw_raddr),
        .rdata (pw_rdata)
    );

    cpi_ram #(.WIDTH(WL_W), .DEPTH(COLUMNS)) u_wl_ram (
        .clk   (clk),
        .we    (wl_we),
        .waddr (wl_waddr),
        .wdata (table_value[WL_W-1:0]),
        .raddr (COL_W'(idx_next)),
        .rdata (wl_rdata)
    );

    // The tables are addressed with the next scan index, so the registered
    // read data always belongs to the current index.
    always_comb
    begin
        case (op)
            OP_IDLE,
            OP_ROW_INIT: idx_next = '0;
            OP_COL_SCAN,
            OP_ROW_SCAN: idx_next = IDX_W'(idx_reg + 1'b1);
            default:     idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        if (32'(rows_in_use) < 2)
        begin
            last_idx = IDX_W'(1);
        end
        else if (32'(rows_in_use) > ROWS)
        begin
            last_idx = IDX_W'(ROWS - 1);
        end
        else
        begin
            last_idx = IDX_W'(rows_in_use - 5'd1);
        end
    end

    // One bit of restoring division per step.
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, dx_reg});
    assign rem_new = q_bit ? X_W'(rem_sh - {1'b0, dx_reg}) : X_W'(rem_sh);
    assign dy      = (y1_reg >= y0_reg) ? (y1_reg - y0_reg) : (y0_reg - y1_reg);
    assign base    = {y0_reg, FRAC_W'(0)};
    assign quot    = num_reg[OUT_W-1:0];

    always_comb
    begin
        flags.no_start  = !(item_accept && (mode == MODE_CONVERT));
        flags.col_more  = (wl_rdata != selected_wavelength) && (32'(idx_reg) != COLUMNS - 1);
        flags.no_column = !col_found_reg;
        flags.row_more  = (idx_reg != last_idx);
        flags.out_range = !brk_found_reg || (x_reg < first_reg) || (x_reg > last_bp_reg);
        flags.zero_dx   = (b_reg <= a_reg);
        flags.div_more  = (cnt_reg != '0);
        flags.out_busy  = res_valid_reg && result_stall;
    end

    assign done_load = (op == OP_DONE) && !flags.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            col_found_reg <= 1'b0;
            brk_found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            case (op)
                OP_IDLE:
                begin
                    col_found_reg <= 1'b0;
                end
                OP_COL_SCAN:
                begin
                    if (wl_rdata == selected_wavelength)
                    begin
                        col_found_reg <= 1'b1;
                    end
                end
                OP_ROW_INIT:
                begin
                    brk_found_reg <= 1'b0;
                end
                OP_ROW_SCAN:
                begin
                    if ((idx_reg != '0) && !brk_found_reg && (prev_reg <= x_reg)
                        && (bp_rdata >= x_reg))
                    begin
                        brk_found_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (done_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_IDLE:
            begin
                if (item_accept)
                begin
                    x_reg     <= intensity;
                    lastp_reg <= last_plane;
                end
            end
            OP_COL_SCAN:
            begin
                if (wl_rdata == selected_wavelength)
                begin
                    col_reg <= COL_W'(idx_reg);
                end
            end
            OP_ROW_SCAN:
            begin
                prev_reg <= bp_rdata;
                if (idx_reg == '0)
                begin
                    first_reg <= bp_rdata;
                end
                else if (!brk_found_reg && (prev_reg <= x_reg) && (bp_rdata >= x_reg))
                begin
                    j_reg <= ROW_W'(idx_reg - 1'b1);
                    a_reg <= prev_reg;
                    b_reg <= bp_rdata;
                end
                if (idx_reg == last_idx)
                begin
                    last_bp_reg <= bp_rdata;
                end
            end
            OP_LOAD_Y0:
            begin
                y0_reg <= pw_rdata;
            end
            OP_LOAD_Y1:
            begin
                y1_reg <= pw_rdata;
            end
            OP_PREP:
            begin
                dx_reg   <= b_reg - a_reg;
                neg_reg  <= (y1_reg < y0_reg);
                prod_reg <= {{X_W{1'b0}}, dy} * {{PWR_W{1'b0}}, X_W'(x_reg - a_reg)};
            end
            OP_DIV_INIT:
            begin
                // Low bits of the scaled product are zero, so the rounding
                // half of the divisor drops straight in.
                num_reg <= {prod_reg, FRAC_W'(dx_reg >> 1)};
                rem_reg <= '0;
                cnt_reg <= DIV_CNT_W'(NUM_W - 1);
            end
            OP_DIV_STEP:
            begin
                num_reg <= {num_reg[NUM_W-2:0], q_bit};
                rem_reg <= rem_new;
                cnt_reg <= DIV_CNT_W'(cnt_reg - 1'b1);
            end
            OP_RESULT:
            begin
                pwr_res_reg <= neg_reg ? (base - quot) : (base + quot);
                st_res_reg  <= STATUS_OK;
            end
            OP_BASE:
            begin
                pwr_res_reg <= base;
                st_res_reg  <= STATUS_OK;
            end
            OP_ERR_WL:
            begin
                pwr_res_reg <= '0;
                st_res_reg  <= STATUS_NO_WL;
            end
            OP_ERR_X:
            begin
                pwr_res_reg <= '0;
                st_res_reg  <= STATUS_RANGE;
            end
            default:
            begin
            end
        endcase
        if (done_load)
        begin
            power_reg  <= pwr_res_reg;
            status_reg <= st_res_reg;
            last_reg   <= lastp_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign power        = power_reg;
    assign status       = status_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_err_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg != STATUS_OK)) |-> (power_reg == '0))
        else $error("failed result carries a non-zero power");

    a_rem_below_dx: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_STEP) |-> (rem_reg < dx_reg))
        else $error("division remainder not below divisor");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ((op == OP_RESULT) && neg_reg) |-> (quot <= base))
        else $error("falling interpolation would go below zero");

    a_fetch_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD_Y0) |-> (brk_found_reg && col_found_reg))
        else $error("power fetch without column and bracket");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/calibrated_power_interpolator.sv -----
`default_nettype none
// Calibrated power interpolator. Load requests (breakpoint, power entry,
// wavelength) are taken while the block is idle and give no result. A convert
// request scans the wavelength list one entry per cycle for the selected
// wavelength, then scans the breakpoints one row per cycle for the first
// bracketing pair, fetches the two power entries and interpolates with a
// 31-step bit-serial divider. Further requests stall until the convert is
// done, and a result that is not yet taken holds the block in its final step.
// Each convert gives exactly one result: power in unsigned Q16.8, with status
// showing a missing wavelength or an intensity outside the table. Table
// entries must be written before a convert reads them, and configuration must
// be written only while no request is in flight.
module calibrated_power_interpolator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 mode,
    input  logic [3:0]                 row,
    input  logic [2:0]                 column,
    input  logic [6:0]                 intensity,
    input  logic [15:0]                table_value,
    input  logic                       last_plane,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [23:0]                power,
    output logic [1:0]                 status,
    output logic                       last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cpi_pkg::*;

    localparam logic REG_SELECTED = 1'b0;
    localparam logic REG_ROWS     = 1'b1;

    logic [WL_W-1:0] sel_wl_reg;
    logic [4:0]      rows_reg;
    logic            cfg_write;
    logic            item_accept;
    op_t             op;
    step_t           step;
    flags_t          flags;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign item_stall  = (step != ST_IDLE);
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_wl_reg <= '0;
            rows_reg   <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SELECTED: sel_wl_reg <= pwdata[WL_W-1:0];
                REG_ROWS:     rows_reg   <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SELECTED: prdata = 32'(sel_wl_reg);
            REG_ROWS:     prdata = 32'(rows_reg);
            default:      prdata = '0;
        endcase
    end

    cpi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op),
        .step  (step)
    );

    cpi_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .flags               (flags),
        .item_accept         (item_accept),
        .mode                (mode),
        .row                 (row),
        .column              (column),
        .intensity           (intensity),
        .table_value         (table_value),
        .last_plane          (last_plane),
        .selected_wavelength (sel_wl_reg),
        .rows_in_use         (rows_reg),
        .result_stall        (result_stall),
        .result_valid        (result_valid),
        .power               (power),
        .status              (status),
        .last                (last)
    );

`ifndef SYNTHESIS
    a_convert_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (mode == MODE_CONVERT)) |=> item_stall)
        else $error("convert request did not start the sequencer");
`endif
endmodule
`default_nettype wire
